// ----- rtl/bsc_pkg.sv -----
// Shared widths, register indexes and types for the barometric compensation core.
package bsc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 23;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SENS          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMPCO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMPCO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE    = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tempco;
    logic [COEF_W-1:0] offset_tempco;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
  } coef_t;

endpackage

// ----- rtl/bsc_in_if.sv -----
// Input channel: one pair of raw pressure and temperature conversions per word.
interface bsc_in_if
  import bsc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_pressure;
  logic [RAW_W-1:0]  raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ----- rtl/bsc_out_if.sv -----
// Result channel: compensated temperature and pressure per word.
interface bsc_out_if
  import bsc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;

  modport source (output valid, output temperature, output pressure, input ready);
  modport sink   (input valid, input temperature, input pressure, output ready);
endinterface

// ----- rtl/bsc_cfg_regs.sv -----
// Calibration word registers written through the plain configuration port.
module bsc_cfg_regs
  import bsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output coef_t                coef
);

  coef_t coef_r;
  coef_t coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SENS:          coef_nxt.sens          = cfg_wdata;
        CFG_OFFSET:        coef_nxt.offset        = cfg_wdata;
        CFG_SENS_TEMPCO:   coef_nxt.sens_tempco   = cfg_wdata;
        CFG_OFFSET_TEMPCO: coef_nxt.offset_tempco = cfg_wdata;
        CFG_REF_TEMP:      coef_nxt.ref_temp      = cfg_wdata;
        CFG_TEMP_SLOPE:    coef_nxt.temp_slope    = cfg_wdata;
        default:           coef_nxt = coef_r;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

// ----- rtl/baro_sensor_compensation_core.sv -----
// Throughput: one word per cycle while out_ch keeps taking words; a six-register pipeline
//   with per-stage valid bits, built around the three parallel 25x17 multiplies and the split 24x34 pressure product.
// Stalls: a stage holds only when the stage after it is full and held, so bubbles fill in.
// Reset (rst_n low, synchronous): clears all valid bits and the six calibration words.
module baro_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bsc_in_if.sink               in_ch,
  bsc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  coef_t coef;

  bsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // ---------------------------------------------------------------------------
  // Flow control: stage k loads when it is empty or the next stage loads too.
  // ---------------------------------------------------------------------------
  logic [6:1] v_r;
  logic [6:1] v_nxt;
  logic [6:1] en;

  always_comb begin
    en[6] = !v_r[6] || out_ch.ready;
    en[5] = !v_r[5] || en[6];
    en[4] = !v_r[4] || en[5];
    en[3] = !v_r[3] || en[4];
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
  end

  assign in_ch.ready = en[1];

  always_comb begin
    v_nxt[1] = en[1] ? in_ch.valid : v_r[1];
    v_nxt[2] = en[2] ? v_r[1]      : v_r[2];
    v_nxt[3] = en[3] ? v_r[2]      : v_r[3];
    v_nxt[4] = en[4] ? v_r[3]      : v_r[4];
    v_nxt[5] = en[5] ? v_r[4]      : v_r[5];
    v_nxt[6] = en[6] ? v_r[5]      : v_r[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: temperature difference dT = D2 - C5 * 2^8 (fits 25 bits signed).
  // ---------------------------------------------------------------------------
  logic signed [24:0] dt_nxt;
  logic signed [24:0] s1_dt_r;
  logic [RAW_W-1:0]   s1_d1_r;

  assign dt_nxt = $signed({1'b0, in_ch.raw_temperature})
                - $signed({1'b0, coef.ref_temp, 8'h00});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dt_r <= dt_nxt;
      s1_d1_r <= in_ch.raw_pressure;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the three dT products, one multiplier each.
  // ---------------------------------------------------------------------------
  logic signed [41:0] prod_t_nxt;
  logic signed [41:0] prod_o_nxt;
  logic signed [41:0] prod_s_nxt;
  logic signed [41:0] s2_prod_t_r;
  logic signed [41:0] s2_prod_o_r;
  logic signed [41:0] s2_prod_s_r;
  logic [RAW_W-1:0]   s2_d1_r;

  assign prod_t_nxt = s1_dt_r * $signed({1'b0, coef.temp_slope});
  assign prod_o_nxt = s1_dt_r * $signed({1'b0, coef.offset_tempco});
  assign prod_s_nxt = s1_dt_r * $signed({1'b0, coef.sens_tempco});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_prod_t_r <= prod_t_nxt;
      s2_prod_o_r <= prod_o_nxt;
      s2_prod_s_r <= prod_s_nxt;
      s2_d1_r     <= s1_d1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: TEMP, OFF and SENS. Taking the upper bits of a signed product is
  // the floor shift.
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] temp_nxt;
  logic signed [35:0]       off_nxt;
  logic signed [33:0]       sens_nxt;
  logic signed [TEMP_W-1:0] s3_temp_r;
  logic signed [35:0]       s3_off_r;
  logic signed [33:0]       s3_sens_r;
  logic [RAW_W-1:0]         s3_d1_r;

  assign temp_nxt = $signed(s2_prod_t_r[41:23]) + TEMP_BASE;
  assign off_nxt  = $signed({s2_prod_o_r[41], s2_prod_o_r[41:7]})
                  + $signed({4'b0000, coef.offset, 16'h0000});
  assign sens_nxt = $signed(s2_prod_s_r[41:8])
                  + $signed({3'b000, coef.sens, 15'h0000});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_temp_r <= temp_nxt;
      s3_off_r  <= off_nxt;
      s3_sens_r <= sens_nxt;
      s3_d1_r   <= s2_d1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: D1 * SENS split into two partial products on the low 17 bits
  // (unsigned) and the high 17 bits (signed) of SENS.
  // ---------------------------------------------------------------------------
  logic [40:0]              pp_lo_nxt;
  logic signed [41:0]       pp_hi_nxt;
  logic [40:0]              s4_pp_lo_r;
  logic signed [41:0]       s4_pp_hi_r;
  logic signed [TEMP_W-1:0] s4_temp_r;
  logic signed [35:0]       s4_off_r;

  assign pp_lo_nxt = {17'h00000, s3_d1_r} * {24'h000000, s3_sens_r[16:0]};
  assign pp_hi_nxt = $signed({1'b0, s3_d1_r}) * $signed(s3_sens_r[33:17]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_pp_lo_r <= pp_lo_nxt;
      s4_pp_hi_r <= pp_hi_nxt;
      s4_temp_r  <= s3_temp_r;
      s4_off_r   <= s3_off_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: merge the partial products and floor shift by 21.
  // ---------------------------------------------------------------------------
  logic signed [58:0]       full_prod;
  logic signed [37:0]       s5_scaled_r;
  logic signed [TEMP_W-1:0] s5_temp_r;
  logic signed [35:0]       s5_off_r;

  assign full_prod = $signed({s4_pp_hi_r, 17'h00000}) + $signed({18'h00000, s4_pp_lo_r});

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_scaled_r <= full_prod[58:21];
      s5_temp_r   <= s4_temp_r;
      s5_off_r    <= s4_off_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: subtract OFF, floor shift by 15, hold in the output register.
  // ---------------------------------------------------------------------------
  logic signed [37:0]       pres_diff;
  logic signed [PRES_W-1:0] s6_pres_r;
  logic signed [TEMP_W-1:0] s6_temp_r;

  assign pres_diff = s5_scaled_r - $signed({{2{s5_off_r[35]}}, s5_off_r});

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_pres_r <= pres_diff[37:15];
      s6_temp_r <= s5_temp_r;
    end
  end

  assign out_ch.valid       = v_r[6];
  assign out_ch.temperature = s6_temp_r;
  assign out_ch.pressure    = s6_pres_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Input back-pressure only when every stage is full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v_r == 6'b111111) && !out_ch.ready)
    else $error("input stalled while the pipeline had room");

  // A held middle stage keeps its word.
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && !en[3] |=> v_r[3] && $stable(s3_sens_r) && $stable(s3_off_r))
    else $error("stage 3 word lost during a stall");

  // A stage fed by a full, advancing predecessor holds a word next cycle.
  a_stage5_fill: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] && en[5] |=> v_r[5])
    else $error("word dropped between stages 4 and 5");

  // The compensated temperature stays inside its documented span.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] |-> (s6_temp_r >= -19'sd129072) && (s6_temp_r <= 19'sd133071))
    else $error("temperature out of range");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the barometric compensation core: predicted readings vs. results.
`timescale 1ns / 1ps

module tb_top;
  import bsc_pkg::*;

  localparam int PIPE_LATENCY   = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PERCENT   = 31;

  // Indexes past the last register; writes there must leave every coefficient alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_TEMP_SLOPE + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  // A plausible factory calibration set, for realistic operating points.
  localparam coef_t TYPICAL_COEFS = '{
    sens:          16'd40127,
    offset:        16'd36924,
    sens_tempco:   16'd23317,
    offset_tempco: 16'd23282,
    ref_temp:      16'd33464,
    temp_slope:    16'd28312
  };
  localparam logic [RAW_W-1:0] TYPICAL_PRESSURE = 24'd9085466;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [PRES_W-1:0] pressure;
  } reading_t;

  // Scoreboard: keep a copy of the calibration words, predict one reading per
  // accepted word and compare readings in order.
  class reading_tracker;
    coef_t    coefs;
    reading_t pending[$];
    int       failures;

    function new();
      coefs    = '0;
      failures = 0;
    endfunction

    function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        CFG_SENS:          coefs.sens          = val;
        CFG_OFFSET:        coefs.offset        = val;
        CFG_SENS_TEMPCO:   coefs.sens_tempco   = val;
        CFG_OFFSET_TEMPCO: coefs.offset_tempco = val;
        CFG_REF_TEMP:      coefs.ref_temp      = val;
        CFG_TEMP_SLOPE:    coefs.temp_slope    = val;
        default: ;
      endcase
    endfunction

    // First-order compensation; >>> on signed 64-bit rounds toward minus infinity.
    function reading_t compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      longint   dt, temp, off, sens, pres;
      reading_t r;
      dt   = longint'(raw_t) - (longint'(coefs.ref_temp) <<< 8);
      temp = 64'sd2000 + ((dt * longint'(coefs.temp_slope)) >>> 23);
      off  = (longint'(coefs.offset) <<< 16)
           + ((longint'(coefs.offset_tempco) * dt) >>> 7);
      sens = (longint'(coefs.sens) <<< 15)
           + ((longint'(coefs.sens_tempco) * dt) >>> 8);
      pres = (((longint'(raw_p) * sens) >>> 21) - off) >>> 15;
      r.temperature = temp[TEMP_W-1:0];
      r.pressure    = pres[PRES_W-1:0];
      return r;
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      pending.push_back(compensate(raw_p, raw_t));
    endfunction

    function void check_result(logic signed [TEMP_W-1:0] temp,
                               logic signed [PRES_W-1:0] pres);
      reading_t want;
      if (pending.size() == 0) begin
        $error("result word with no reading expected: temperature %0d pressure %0d",
               temp, pres);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (temp !== want.temperature) begin
        $error("temperature: expected %0d, actual %0d", want.temperature, temp);
        failures++;
      end
      if (pres !== want.pressure) begin
        $error("pressure: expected %0d, actual %0d", want.pressure, pres);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_wdata;
  bit   steady;  // high: neither side idles

  bsc_in_if  in_ch();
  bsc_out_if out_ch();

  reading_tracker sb = new();

  baro_sensor_compensation_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Write one register at the next edge; leave cfg_we high for a following write.
  task automatic put_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_coef(idx, val);
  endtask

  // Load a full calibration set, plus two writes to unused indexes, then drop cfg_we.
  task automatic load_coefs(input coef_t c);
    put_coef(CFG_SENS,          c.sens);
    put_coef(CFG_UNUSED_LO,     COEF_W'($urandom));
    put_coef(CFG_OFFSET,        c.offset);
    put_coef(CFG_SENS_TEMPCO,   c.sens_tempco);
    put_coef(CFG_OFFSET_TEMPCO, c.offset_tempco);
    put_coef(CFG_REF_TEMP,      c.ref_temp);
    put_coef(CFG_TEMP_SLOPE,    c.temp_slope);
    put_coef(CFG_UNUSED_HI,     COEF_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word; idle first at random, then hold valid until it is taken.
  task automatic send_sample(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.raw_pressure    <= raw_p;
    in_ch.raw_temperature <= raw_t;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(raw_p, raw_t);
  endtask

  // Drop valid, wait for every reading, then let the pipeline settle.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic coef_t pick_coef_set();
    coef_t c;
    c.sens          = pick_coef();
    c.offset        = pick_coef();
    c.sens_tempco   = pick_coef();
    c.offset_tempco = pick_coef();
    c.ref_temp      = pick_coef();
    c.temp_slope    = pick_coef();
    return c;
  endfunction

  // Mostly near the reference temperature, so dT stays small and of either sign.
  function automatic logic [RAW_W-1:0] pick_temperature();
    logic [RAW_W-1:0] ref_raw;
    ref_raw = {sb.coefs.ref_temp, 8'h00};
    case ($urandom_range(5))
      0, 1, 2: return ref_raw + RAW_W'($urandom_range(2 ** 21)) - RAW_W'(2 ** 20);
      3:       return RAW_W'($urandom);
      4:       return ref_raw - RAW_W'($urandom_range(1));
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_pressure();
    case ($urandom_range(4))
      0, 1:    return RAW_W'($urandom);
      2, 3:    return TYPICAL_PRESSURE + RAW_W'($urandom_range(2 ** 22)) - RAW_W'(2 ** 21);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // Field extremes, dT of zero, minus one and plus one, and alternating bit patterns.
  task automatic run_directed;
    logic [RAW_W-1:0] ref_raw;
    ref_raw = {sb.coefs.ref_temp, 8'h00};
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample('0, '1);
    send_sample('1, '0);
    send_sample(TYPICAL_PRESSURE, ref_raw);
    send_sample(TYPICAL_PRESSURE, ref_raw - 24'd1);
    send_sample(24'd1, ref_raw + 24'd1);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h555555, 24'hAAAAAA);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_sample(pick_pressure(), pick_temperature());
  endtask

  // Result side: check each accepted word, stall at random unless steady.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.temperature, out_ch.pressure);
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.raw_pressure    <= '0;
    in_ch.raw_temperature <= '0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_wdata             <= '0;
    rst_n                 <= 1'b0;
    steady                 = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Run a few words on the reset calibration (all zero) first.
    run_random(20);
    drain();

    // Directed words on a realistic set and on all-ones coefficients.
    load_coefs(TYPICAL_COEFS);
    run_directed();
    drain();
    load_coefs('1);
    run_directed();
    drain();

    // Random words on the extreme sets.
    run_random(150);
    drain();
    load_coefs('0);
    run_random(130);
    drain();

    // Realistic set: a long stretch with no idling, then with idling again.
    load_coefs(TYPICAL_COEFS);
    steady = 1'b1;
    run_random(200);
    steady = 1'b0;
    run_random(100);
    drain();

    // Random calibration sets, each a mix of zero, all-ones and random words.
    repeat (5) begin
      load_coefs(pick_coef_set());
      run_random(120);
      drain();
    end

    if (sb.failures == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bsc_pkg.sv
rtl/bsc_in_if.sv
rtl/bsc_out_if.sv
rtl/bsc_cfg_regs.sv
rtl/baro_sensor_compensation_core.sv
test/tb_top.sv
